>>> src/lppd_pkg.sv
// shared types and constants for the length-prefixed package deframer
package lppd_pkg;

  localparam int unsigned SEQ_BYTES    = 8;
  localparam int unsigned HEADER_BYTES = 13;

  localparam logic [15:0] K_TOPIC_HI = 16'd8;
  localparam logic [15:0] K_TOPIC_LO = 16'd9;
  localparam logic [15:0] K_MSG_HI   = 16'd10;
  localparam logic [15:0] K_MSG_LO   = 16'd11;
  localparam logic [15:0] K_LAST     = 16'(HEADER_BYTES - 1);
  localparam logic [15:0] K_SEQ_END  = 16'(SEQ_BYTES);

  localparam logic [1:0] SEC_HEADER  = 2'd0;
  localparam logic [1:0] SEC_TOPIC   = 2'd1;
  localparam logic [1:0] SEC_MESSAGE = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TOPIC   = 2'd1,
    PH_MESSAGE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [1:0]  section;
    logic [63:0] sequence_number;
    logic [15:0] topic_size;
    logic [15:0] message_length;
    logic [7:0]  message_type;
    logic        header_valid;
    logic        package_end;
  } result_t;

endpackage

>>> src/lppd_parser.sv
// section tracking, header capture and per-byte result for the deframer
module lppd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           data_byte,
  output lppd_pkg::result_t    res
);

  lppd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] mlen_r, mlen_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [1:0]  sec;
  logic        hv;
  logic        pend;
  logic [16:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lppd_pkg::PH_HEADER;
      cnt_r   <= '0;
      seq_r   <= '0;
      tlen_r  <= '0;
      mlen_r  <= '0;
      type_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      seq_r   <= seq_nxt;
      tlen_r  <= tlen_nxt;
      mlen_r  <= mlen_nxt;
      type_r  <= type_nxt;
    end
  end

  assign cnt_inc = {1'b0, cnt_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    seq_nxt   = seq_r;
    tlen_nxt  = tlen_r;
    mlen_nxt  = mlen_r;
    type_nxt  = type_r;
    sec       = lppd_pkg::SEC_HEADER;
    hv        = 1'b0;
    pend      = 1'b0;
    unique case (phase_r)
      lppd_pkg::PH_TOPIC: begin
        sec = lppd_pkg::SEC_TOPIC;
        hv  = 1'b1;
        if (cnt_inc >= {1'b0, tlen_r}) begin
          cnt_nxt = '0;
          if (mlen_r == 16'd0) begin
            pend      = 1'b1;
            phase_nxt = lppd_pkg::PH_HEADER;
          end else begin
            phase_nxt = lppd_pkg::PH_MESSAGE;
          end
        end else begin
          cnt_nxt = cnt_inc[15:0];
        end
      end
      lppd_pkg::PH_MESSAGE: begin
        sec = lppd_pkg::SEC_MESSAGE;
        hv  = 1'b1;
        if (cnt_inc >= {1'b0, mlen_r}) begin
          cnt_nxt   = '0;
          pend      = 1'b1;
          phase_nxt = lppd_pkg::PH_HEADER;
        end else begin
          cnt_nxt = cnt_inc[15:0];
        end
      end
      default: begin
        // unused phase code behaves as header
        sec = lppd_pkg::SEC_HEADER;
        if (cnt_r == 16'd0) begin
          seq_nxt = {56'd0, data_byte};
        end else if (cnt_r < lppd_pkg::K_SEQ_END) begin
          seq_nxt = {seq_r[55:0], data_byte};
        end else if (cnt_r == lppd_pkg::K_TOPIC_HI) begin
          tlen_nxt = {data_byte, 8'd0};
        end else if (cnt_r == lppd_pkg::K_TOPIC_LO) begin
          tlen_nxt = {tlen_r[15:8], tlen_r[7:0] | data_byte};
        end else if (cnt_r == lppd_pkg::K_MSG_HI) begin
          mlen_nxt = {data_byte, 8'd0};
        end else if (cnt_r == lppd_pkg::K_MSG_LO) begin
          mlen_nxt = {mlen_r[15:8], mlen_r[7:0] | data_byte};
        end else begin
          type_nxt = data_byte;
        end
        if (cnt_r >= lppd_pkg::K_LAST) begin
          hv      = 1'b1;
          cnt_nxt = '0;
          if (tlen_nxt != 16'd0) begin
            phase_nxt = lppd_pkg::PH_TOPIC;
          end else if (mlen_nxt != 16'd0) begin
            phase_nxt = lppd_pkg::PH_MESSAGE;
          end else begin
            phase_nxt = lppd_pkg::PH_HEADER;
            pend      = 1'b1;
          end
        end else begin
          cnt_nxt   = cnt_inc[15:0];
          phase_nxt = lppd_pkg::PH_HEADER;
        end
      end
    endcase

    res.echo_byte       = data_byte;
    res.section         = sec;
    res.sequence_number = hv ? seq_nxt : 64'd0;
    res.topic_size      = hv ? tlen_nxt : 16'd0;
    res.message_length  = hv ? mlen_nxt : 16'd0;
    res.message_type    = hv ? type_nxt : 8'd0;
    res.header_valid    = hv;
    res.package_end     = pend;
  end

endmodule

>>> src/length_prefixed_package_deframer.sv
// top level of the length-prefixed package deframer
// Usage:
//   in_valid/in_ready/in_data_byte carry the raw package stream, one byte per
//   request. Each package is a 13-byte big-endian header (sequence number,
//   topic length, message length, type) followed by topic and message bytes.
//   out_valid/out_ready carry one result per input byte: the echoed byte, its
//   section, the decoded header fields once the header is complete, and a
//   package_end flag on the last byte of each package.
// Output: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; per-byte work is the section
//   counter compare and the header shift between state and result register.
// Reset: rst_n (synchronous, active low) returns the parser to the start of
//   a header with all captured fields cleared and drops out_valid.
// Stall: while out_ready is low a valid result is held and in_ready is low;
//   a byte is still taken in the same cycle that the held result leaves.
module length_prefixed_package_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_echo_byte,
  output logic [1:0]  out_section,
  output logic [63:0] out_sequence_number,
  output logic [15:0] out_topic_size,
  output logic [15:0] out_message_length,
  output logic [7:0]  out_message_type,
  output logic        out_header_valid,
  output logic        out_package_end
);

  lppd_pkg::result_t res;
  lppd_pkg::result_t res_r;
  logic              valid_r;
  logic              in_fire;

  assign in_ready = !valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  lppd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_echo_byte       = res_r.echo_byte;
  assign out_section         = res_r.section;
  assign out_sequence_number = res_r.sequence_number;
  assign out_topic_size      = res_r.topic_size;
  assign out_message_length  = res_r.message_length;
  assign out_message_type    = res_r.message_type;
  assign out_header_valid    = res_r.header_valid;
  assign out_package_end     = res_r.package_end;

endmodule
